// ===== rtl/bwsm_pkg.sv =====
package bwsm_pkg;

  // Fixed filter gains and coefficients (signed, Q3.30 for the feedback terms).
  localparam logic signed [48:0] FEED_GAIN = 49'sd6035133914;
  localparam logic signed [32:0] COEF0     = 33'sd1000749826;
  localparam logic signed [32:0] COEF1     = -33'sd3068819480;
  localparam logic signed [32:0] COEF2     = 33'sd3141627300;

  localparam logic [16:0] Q_ONE16 = 17'd65536;

  // Register map, one word index per register.
  localparam logic [1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [1:0] REG_BANDWIDTH = 2'd1;
  localparam logic [1:0] REG_PAN_LEFT  = 2'd2;
  localparam logic [1:0] REG_STEREO    = 2'd3;

  // Multiply-and-round operations run in sequence on the shared multiplier.
  typedef enum logic [2:0] {
    OP_FEED  = 3'd0,
    OP_C0    = 3'd1,
    OP_C1    = 3'd2,
    OP_C2    = 3'd3,
    OP_ENV   = 3'd4,
    OP_VAL   = 3'd5,
    OP_LEFT  = 3'd6,
    OP_RIGHT = 3'd7
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic ld;
    logic mlo;
    logic mhi;
    logic acc;
    logic wb;
    logic out_load;
    op_t  op;
  } bwsm_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic bw_zero;
    logic stereo;
    logic sqrt_done;
    logic out_free;
  } bwsm_stat_t;

  // Saturate to the signed 24-bit range.
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

  // Saturate to the signed 48-bit range.
  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh00007FFFFFFFFFFF) begin
      return 48'sh7FFFFFFFFFFF;
    end else if (v < -64'sh0000800000000000) begin
      return 48'sh800000000000;
    end else begin
      return v[47:0];
    end
  endfunction

endpackage

// ===== rtl/bwsm_sqrt.sv =====
// Floor square root of a 50-bit radicand, one result bit per cycle.
module bwsm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [49:0] radicand,
  output logic [24:0] root,
  output logic        done
);

  logic [49:0] rad_r,  rad_nxt;
  logic [26:0] rem_r,  rem_nxt;
  logic [24:0] root_r, root_nxt;
  logic [4:0]  cnt_r,  cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [28:0] rem_t;
  logic [28:0] trial;

  assign rem_t = {rem_r, rad_r[49:48]};
  assign trial = {2'b00, root_r, 2'b01};

  // Restoring digit recurrence.
  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'd24;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[47:0], 2'b00};
      if (rem_t >= trial) begin
        rem_nxt  = 27'(rem_t - trial);
        root_nxt = {root_r[23:0], 1'b1};
      end else begin
        rem_nxt  = rem_t[26:0];
        root_nxt = {root_r[23:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// ===== rtl/bwsm_dp.sv =====
// Datapath: histories, shared 32x32 multiplier with rounding, output register.
module bwsm_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bwsm_pkg::bwsm_cmd_t   cmd,
  output bwsm_pkg::bwsm_stat_t  stat,
  input  logic [14:0]           amplitude,
  input  logic [16:0]           bandwidth,
  input  logic [16:0]           pan_left,
  input  logic                  stereo_mode,
  input  logic signed [15:0]    osc_in,
  input  logic signed [15:0]    noise_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [23:0]    left_out,
  output logic signed [23:0]    right_out
);

  logic [16:0] bw_c;
  logic [16:0] pan_c;

  logic signed [15:0] x_r;
  logic signed [30:0] oa_r;
  logic signed [15:0] n0_r, n1_r, n2_r;
  logic signed [47:0] f0_r, f1_r, f2_r;
  logic signed [63:0] yacc_r;
  logic signed [47:0] y_r;
  logic signed [39:0] env_r;
  logic signed [39:0] v_r;
  logic signed [23:0] left_r, right_r;
  logic signed [23:0] left_out_r, right_out_r;
  logic               out_valid_r;

  logic [47:0] a_mag_r;
  logic [31:0] b_mag_r;
  logic        neg_r;
  logic [63:0] prod_r;
  logic [79:0] acc_r;

  logic signed [48:0] a_sel;
  logic signed [32:0] b_sel;
  logic signed [48:0] a_abs;
  logic signed [32:0] b_abs;
  logic signed [19:0] nsum;
  logic [6:0]         sh;
  logic [79:0]        shifted;
  logic [63:0]        rmag;
  logic signed [63:0] res;
  logic signed [63:0] ysum;
  logic signed [47:0] ynew;
  logic signed [31:0] oa_full;

  logic [49:0] rad1, rad2;
  logic [24:0] s1, s2;
  logic        d1, d2;

  // Clamp the Q1.16 registers to 1.0.
  assign bw_c  = (bandwidth > bwsm_pkg::Q_ONE16) ? bwsm_pkg::Q_ONE16 : bandwidth;
  assign pan_c = (pan_left > bwsm_pkg::Q_ONE16) ? bwsm_pkg::Q_ONE16 : pan_left;

  // Square roots of the two envelope weights, Q1.24.
  assign rad1 = {1'b0, 17'(bwsm_pkg::Q_ONE16 - bw_c), 32'd0};
  assign rad2 = {bw_c, 1'b0, 32'd0};

  bwsm_sqrt u_sqrt1 (
    .clk(clk), .rst_n(rst_n), .start(cmd.capture), .radicand(rad1), .root(s1), .done(d1)
  );
  bwsm_sqrt u_sqrt2 (
    .clk(clk), .rst_n(rst_n), .start(cmd.capture), .radicand(rad2), .root(s2), .done(d2)
  );

  // Filter feed sum over the noise history.
  assign nsum = 20'(n0_r) + 20'(x_r) + 20'(3) * (20'(n1_r) + 20'(n2_r));

  assign oa_full = $signed(osc_in) * $signed({1'b0, amplitude});

  // Operand and shift selection for each operation.
  always_comb begin
    a_sel = '0;
    b_sel = '0;
    sh    = 7'd30;
    case (cmd.op)
      bwsm_pkg::OP_FEED: begin
        a_sel = bwsm_pkg::FEED_GAIN;
        b_sel = 33'(nsum);
        sh    = 7'd20;
      end
      bwsm_pkg::OP_C0: begin
        a_sel = 49'(f0_r);
        b_sel = bwsm_pkg::COEF0;
      end
      bwsm_pkg::OP_C1: begin
        a_sel = 49'(f1_r);
        b_sel = bwsm_pkg::COEF1;
      end
      bwsm_pkg::OP_C2: begin
        a_sel = 49'(f2_r);
        b_sel = bwsm_pkg::COEF2;
      end
      bwsm_pkg::OP_ENV: begin
        a_sel = 49'(y_r);
        b_sel = $signed({8'd0, s2});
        sh    = 7'd40;
      end
      bwsm_pkg::OP_VAL: begin
        a_sel = 49'(env_r);
        b_sel = 33'(oa_r);
        sh    = 7'd31;
      end
      bwsm_pkg::OP_LEFT: begin
        a_sel = 49'(v_r);
        b_sel = stereo_mode ? $signed({16'd0, pan_c}) : 33'sd1;
        sh    = stereo_mode ? 7'd24 : 7'd8;
      end
      bwsm_pkg::OP_RIGHT: begin
        a_sel = 49'(v_r);
        b_sel = $signed({16'd0, 17'(bwsm_pkg::Q_ONE16 - pan_c)});
        sh    = 7'd24;
      end
      default: begin
        a_sel = '0;
      end
    endcase
  end

  assign a_abs = a_sel[48] ? -a_sel : a_sel;
  assign b_abs = b_sel[32] ? -b_sel : b_sel;

  // Round half away from zero on the magnitude, then restore the sign.
  assign shifted = acc_r >> sh;
  assign rmag    = shifted[63:0] + 64'(acc_r[7'(sh - 7'd1)]);
  assign res     = neg_r ? -$signed(rmag) : $signed(rmag);
  assign ysum    = yacc_r + res;
  assign ynew    = bwsm_pkg::sat48(ysum);

  // Multiplier pipeline: low half, high half, accumulate.
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      a_mag_r <= a_abs[47:0];
      b_mag_r <= b_abs[31:0];
      neg_r   <= a_sel[48] ^ b_sel[32];
    end
    if (cmd.mlo) begin
      prod_r <= 64'(a_mag_r[31:0]) * 64'(b_mag_r);
    end
    if (cmd.mhi) begin
      acc_r  <= {16'd0, prod_r};
      prod_r <= 64'(a_mag_r[47:32]) * 64'(b_mag_r);
    end
    if (cmd.acc) begin
      acc_r <= acc_r + {prod_r[47:0], 32'd0};
    end
  end

  // Item capture and write-back of each operation.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r     <= noise_in;
      oa_r    <= oa_full[30:0];
      env_r   <= 40'sd16777216;
      right_r <= '0;
    end
    if (cmd.wb) begin
      case (cmd.op)
        bwsm_pkg::OP_FEED:  yacc_r  <= res;
        bwsm_pkg::OP_C0:    yacc_r  <= ysum;
        bwsm_pkg::OP_C1:    yacc_r  <= ysum;
        bwsm_pkg::OP_C2:    y_r     <= ynew;
        bwsm_pkg::OP_ENV:   env_r   <= 40'($signed({15'd0, s1})) + res[39:0];
        bwsm_pkg::OP_VAL:   v_r     <= res[39:0];
        bwsm_pkg::OP_LEFT:  left_r  <= bwsm_pkg::sat24(res);
        bwsm_pkg::OP_RIGHT: right_r <= bwsm_pkg::sat24(res);
        default: yacc_r <= yacc_r;
      endcase
    end
  end

  // Filter and noise histories advance once the new output is known.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n0_r <= '0;
      n1_r <= '0;
      n2_r <= '0;
      f0_r <= '0;
      f1_r <= '0;
      f2_r <= '0;
    end else if (cmd.wb && cmd.op == bwsm_pkg::OP_C2) begin
      n0_r <= n1_r;
      n1_r <= n2_r;
      n2_r <= x_r;
      f0_r <= f1_r;
      f1_r <= f2_r;
      f2_r <= ynew;
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output beat data, held while the beat waits so the next item can run.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_out_r  <= left_r;
      right_out_r <= right_r;
    end
  end

  assign out_valid = out_valid_r;
  assign left_out  = left_out_r;
  assign right_out = right_out_r;

  assign stat.bw_zero   = (bw_c == 17'd0);
  assign stat.stereo    = stereo_mode;
  assign stat.sqrt_done = d1 & d2;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

// ===== rtl/bwsm_ctrl.sv =====
// Controller: steps the operation list through the shared multiplier.
module bwsm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bwsm_pkg::bwsm_stat_t stat,
  output bwsm_pkg::bwsm_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_MLO  = 7'b0000100,
    S_MHI  = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_WB   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  bwsm_pkg::op_t   op_r, op_nxt;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.op       = op_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          op_nxt      = stat.bw_zero ? bwsm_pkg::OP_VAL : bwsm_pkg::OP_FEED;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        // The envelope step needs both square roots.
        if (op_r != bwsm_pkg::OP_ENV || stat.sqrt_done) begin
          cmd.ld    = 1'b1;
          state_nxt = S_MLO;
        end
      end
      S_MLO: begin
        cmd.mlo   = 1'b1;
        state_nxt = S_MHI;
      end
      S_MHI: begin
        cmd.mhi   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_LOAD;
        case (op_r)
          bwsm_pkg::OP_FEED: op_nxt = bwsm_pkg::OP_C0;
          bwsm_pkg::OP_C0:   op_nxt = bwsm_pkg::OP_C1;
          bwsm_pkg::OP_C1:   op_nxt = bwsm_pkg::OP_C2;
          bwsm_pkg::OP_C2:   op_nxt = bwsm_pkg::OP_ENV;
          bwsm_pkg::OP_ENV:  op_nxt = bwsm_pkg::OP_VAL;
          bwsm_pkg::OP_VAL:  op_nxt = bwsm_pkg::OP_LEFT;
          bwsm_pkg::OP_LEFT: begin
            if (stat.stereo) begin
              op_nxt = bwsm_pkg::OP_RIGHT;
            end else begin
              state_nxt = S_OUT;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/bandwidth_enhanced_sine_modulator_core.sv =====
// Channel   Direction  Beat contents
// in_       slave      tdata: osc_sample [15:0], noise_sample [31:16]
// out_      master     tdata: left_sample [23:0], right_sample [47:24]
// cfg (APB) slave      amplitude 0x0, bandwidth 0x4, pan_left 0x8, stereo_mode 0xC
//
// Each multiply-and-round step runs the load, low-half, high-half, accumulate and
// write-back states on the one shared 32x32 multiplier, eight steps in the full
// case; zero bandwidth skips the filter and envelope steps, mono the right step,
// and the envelope step waits for the square roots. An accept state and an output
// state frame each item. The output state stalls while the previous beat is held.
// Reset is synchronous, clears the histories, the controller and the output valid,
// and loads the register defaults. A new beat is taken while the previous result still waits on out_tready.
module bandwidth_enhanced_sine_modulator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // osc_sample [15:0], noise_sample [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // left_sample [23:0], right_sample [47:24]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [14:0] amplitude_r;
  logic [16:0] bandwidth_r;
  logic [16:0] pan_left_r;
  logic        stereo_r;

  bwsm_pkg::bwsm_cmd_t  cmd;
  bwsm_pkg::bwsm_stat_t stat;
  logic signed [23:0]   left_s, right_s;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r <= '0;
      bandwidth_r <= '0;
      pan_left_r  <= 17'd32768;
      stereo_r    <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        bwsm_pkg::REG_AMPLITUDE: amplitude_r <= pwdata[14:0];
        bwsm_pkg::REG_BANDWIDTH: bandwidth_r <= pwdata[16:0];
        bwsm_pkg::REG_PAN_LEFT:  pan_left_r  <= pwdata[16:0];
        bwsm_pkg::REG_STEREO:    stereo_r    <= pwdata[0];
        default:                 stereo_r    <= stereo_r;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      bwsm_pkg::REG_AMPLITUDE: prdata = {17'd0, amplitude_r};
      bwsm_pkg::REG_BANDWIDTH: prdata = {15'd0, bandwidth_r};
      bwsm_pkg::REG_PAN_LEFT:  prdata = {15'd0, pan_left_r};
      bwsm_pkg::REG_STEREO:    prdata = {31'd0, stereo_r};
      default:                 prdata = '0;
    endcase
  end

  bwsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bwsm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .amplitude   (amplitude_r),
    .bandwidth   (bandwidth_r),
    .pan_left    (pan_left_r),
    .stereo_mode (stereo_r),
    .osc_in      (in_tdata[15:0]),
    .noise_in    (in_tdata[31:16]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .left_out    (left_s),
    .right_out   (right_s)
  );

  assign out_tdata = {right_s, left_s};

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [23:0] right_sample;
    logic [23:0] left_sample;
  } stereo_pair_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // osc_sample [15:0], noise_sample [31:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // left_sample [23:0], right_sample [47:24]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the register file and the filter state.
  logic [14:0] gain_q;
  logic [16:0] bw_q;
  logic [16:0] pan_q;
  logic        stereo_q;
  longint      raw_noise [3];
  longint      lowpass_out [3];

  stereo_pair_t pending_pairs[$];
  int           error_count;
  int           cycle_count;
  bit           steady_flow;

  bandwidth_enhanced_sine_modulator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round(a*b / 2^s), half away from zero.
  function automatic logic signed [127:0] mul_round(input logic signed [127:0] a,
                                                     input logic signed [127:0] b,
                                                     input int s);
    logic signed [127:0] prod;
    logic [127:0]        mag;
    prod = a * b;
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag >> s) + ((mag >> (s - 1)) & 128'd1);
    return (prod < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // Floor square root, one result bit at a time.
  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return longint'(root);
  endfunction

  function automatic logic signed [127:0] clip(input logic signed [127:0] v,
                                               input logic signed [127:0] lo,
                                               input logic signed [127:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Expected output pair for one beat; advances the filter when bandwidth is nonzero.
  function automatic stereo_pair_t modulate(input logic signed [15:0] osc,
                                            input logic signed [15:0] noise);
    logic signed [127:0] envelope, level, lsum, rsum, y, acc;
    longint              bw, pan, s1, s2;
    stereo_pair_t        pair;
    bw  = (bw_q > 17'd65536) ? 65536 : longint'(bw_q);
    pan = (pan_q > 17'd65536) ? 65536 : longint'(pan_q);
    if (bw == 0) begin
      envelope = 128'sd1 << 24;
    end else begin
      acc = raw_noise[0] + longint'(noise) + 3 * (raw_noise[1] + raw_noise[2]);
      y = mul_round(128'sd6035133914, acc, 20);
      y += mul_round(lowpass_out[0], 128'sd1000749826, 30);
      y += mul_round(lowpass_out[1], -128'sd3068819480, 30);
      y += mul_round(lowpass_out[2], 128'sd3141627300, 30);
      y = clip(y, -(128'sd1 <<< 47), (128'sd1 <<< 47) - 1);
      raw_noise[0]   = raw_noise[1];
      raw_noise[1]   = raw_noise[2];
      raw_noise[2]   = longint'(noise);
      lowpass_out[0] = lowpass_out[1];
      lowpass_out[1] = lowpass_out[2];
      lowpass_out[2] = longint'(y);
      s1 = floor_sqrt(longint'(65536 - bw) << 32);
      s2 = floor_sqrt(longint'(2 * bw) << 32);
      envelope = s1 + mul_round(y, s2, 40);
    end
    level = mul_round(envelope, longint'(osc) * longint'(gain_q), 31);
    if (stereo_q) begin
      lsum = mul_round(level, pan, 24);
      rsum = mul_round(level, 65536 - pan, 24);
    end else begin
      lsum = mul_round(level, 1, 8);
      rsum = 0;
    end
    pair.left_sample  = 24'(clip(lsum, -128'sd8388608, 128'sd8388607));
    pair.right_sample = 24'(clip(rsum, -128'sd8388608, 128'sd8388607));
    return pair;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      bwsm_pkg::REG_AMPLITUDE: gain_q   = value[14:0];
      bwsm_pkg::REG_BANDWIDTH: bw_q     = value[16:0];
      bwsm_pkg::REG_PAN_LEFT:  pan_q    = value[16:0];
      bwsm_pkg::REG_STEREO:    stereo_q = value[0];
      default: ;
    endcase
  endtask

  task automatic program_all(input int gain, input int bw, input int pan, input bit st);
    write_reg(bwsm_pkg::REG_AMPLITUDE, gain);
    write_reg(bwsm_pkg::REG_BANDWIDTH, bw);
    write_reg(bwsm_pkg::REG_PAN_LEFT, pan);
    write_reg(bwsm_pkg::REG_STEREO, 32'(st));
  endtask

  // Send one beat; valid stays high into the next call when no gap is drawn.
  task automatic send_beat(input logic [15:0] osc, input logic [15:0] noise);
    int gap;
    in_tvalid = 1'b1;
    in_tdata  = {noise, osc};
    do @(posedge clk); while (!in_tready);
    pending_pairs.push_back(modulate(osc, noise));
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Wait until every expected result has come, leaving the input idle.
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_extremes();
    logic [15:0] corner [5];
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h5555};
    foreach (corner[i]) begin
      send_beat(corner[i], corner[4 - i]);
    end
  endtask

  task automatic test_reset_values();
    send_beat(16'h7FFF, 16'h1234);
    drain();
  endtask

  task automatic test_zero_bandwidth();
    program_all(32767, 0, 65536, 1);
    send_extremes();
    drain();
  endtask

  task automatic test_full_bandwidth();
    program_all(32767, 65536, 0, 1);
    send_extremes();
    send_beat(16'h7FFF, 16'h7FFF);
    send_beat(16'h8000, 16'h8000);
    drain();
  endtask

  task automatic test_mono_and_clamps();
    program_all(20000, 131071, 131071, 0);
    send_extremes();
    drain();
    write_reg(bwsm_pkg::REG_STEREO, 32'd1);
    send_extremes();
    drain();
  endtask

  task automatic test_random_traffic();
    logic [15:0] osc, noise;
    for (int phase = 0; phase < 10; phase++) begin
      program_all($urandom_range(0, 32767),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                              : $urandom_range(0, 3) * 21845,
                  $urandom_range(0, 131071), $urandom_range(0, 1));
      steady_flow = (phase % 3 == 1);
      for (int n = 0; n < 92; n++) begin
        osc = $urandom();
        noise = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                            : 16'($signed($urandom_range(0, 16383)) - 8192);
        send_beat(osc, noise);
      end
      steady_flow = 1'b0;
      drain();
    end
  endtask

  // Result stall pattern.
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    stereo_pair_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_pairs.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        error_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (got.left_sample !== want.left_sample) begin
          $error("left_sample expected %0d actual %0d",
                 $signed(want.left_sample), $signed(got.left_sample));
          error_count++;
        end
        if (got.right_sample !== want.right_sample) begin
          $error("right_sample expected %0d actual %0d",
                 $signed(want.right_sample), $signed(got.right_sample));
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    cycle_count = 0;
    steady_flow = 1'b0;
    gain_q = '0;
    bw_q = '0;
    pan_q = 17'd32768;
    stereo_q = 1'b1;
    foreach (raw_noise[i]) begin
      raw_noise[i] = 0;
      lowpass_out[i] = 0;
    end
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_zero_bandwidth();
    test_full_bandwidth();
    test_mono_and_clamps();
    test_random_traffic();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bwsm_pkg.sv
rtl/bwsm_sqrt.sv
rtl/bwsm_dp.sv
rtl/bwsm_ctrl.sv
rtl/bandwidth_enhanced_sine_modulator_core.sv
dv/tb_top.sv
